// ===== hdl/mabsg_pkg.sv =====
// Package for the multi-axis Bresenham step generator.
// Holds widths, operation and status codes, and the structs shared by the lane, merge, output buffer and top modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mabsg_pkg;

    // Fixed configuration of the generator
    localparam int MAX_AXES  = 3;
    localparam int STEP_BITS = 24;
    localparam int MAG_W     = STEP_BITS - 1;
    localparam int ERR_W     = STEP_BITS + 1;
    localparam int AXIS_W    = 3;
    localparam int CFG_W     = 2;

    localparam logic [CFG_W-1:0] AXES_RESET = CFG_W'(3);
    localparam logic [MAG_W-1:0] MAG_MAX    = {MAG_W{1'b1}};

    // Operation codes of the func field
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Load status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_BUSY = 1'b1;

    // Per-lane control from the sequencer
    typedef struct packed {
        logic load;   // segment load accepted this cycle
        logic step;   // tick executes a step period this cycle
        logic live;   // lane index below the axes in use
        logic sel;    // lane enabled by the load's axis mask
    } lane_ctrl_t;

    // One result transaction
    typedef struct packed {
        logic              load_status;
        logic              running;
        logic [AXIS_W-1:0] step_pulses;
        logic [AXIS_W-1:0] dir_pins;
    } result_t;

endpackage : mabsg_pkg

`default_nettype wire

// ===== hdl/mabsg_lane.sv =====
// One axis lane: magnitude, error term and direction pin of a single axis.
// Computes the saturated magnitude on load and one Bresenham step per executed step period.
// Depends on mabsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mabsg_lane
    import mabsg_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lane_ctrl_t                  ctrl,
    input  wire logic signed [STEP_BITS-1:0] steps,
    input  wire logic        [MAG_W-1:0]     major_count,
    output logic             [MAG_W-1:0]     load_mag,
    output logic                             pulse,
    output logic                             dir_next
);

    logic        [MAG_W-1:0]     mag_reg, mag_next;
    logic signed [ERR_W-1:0]     err_reg, err_next;
    logic                        dir_reg;
    logic        [STEP_BITS-1:0] neg_steps;
    logic                        is_neg;
    logic signed [ERR_W-1:0]     err_sum;
    logic signed [ERR_W:0]       err_twice;
    logic signed [ERR_W:0]       major_ext;

    // Magnitude of the incoming count; most negative value saturates; zero for lanes not live or not selected
    always_comb
    begin
        is_neg    = steps[STEP_BITS-1];
        neg_steps = STEP_BITS'(-steps);
        if (!(ctrl.live && ctrl.sel))
            load_mag = '0;
        else if (!is_neg)
            load_mag = steps[MAG_W-1:0];
        else if (neg_steps[STEP_BITS-1])
            load_mag = MAG_MAX;
        else
            load_mag = neg_steps[MAG_W-1:0];
    end

    // Bresenham step: accumulate, compare twice the error with the major count
    always_comb
    begin
        err_sum   = err_reg + signed'({{(ERR_W-MAG_W){1'b0}}, mag_reg});
        err_twice = {err_sum, 1'b0};
        major_ext = signed'({{(ERR_W+1-MAG_W){1'b0}}, major_count});
        pulse     = 1'b0;
        mag_next  = mag_reg;
        err_next  = err_reg;
        dir_next  = dir_reg;
        if (ctrl.load)
        begin
            mag_next = load_mag;
            err_next = '0;
            if (ctrl.live && ctrl.sel)
                dir_next = !is_neg;
        end
        else if (ctrl.step && ctrl.live)
        begin
            if (err_twice >= major_ext)
            begin
                pulse    = 1'b1;
                err_next = err_sum - signed'({{(ERR_W-MAG_W){1'b0}}, major_count});
            end
            else
            begin
                err_next = err_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg <= '0;
            err_reg <= '0;
            dir_reg <= 1'b0;
        end
        else
        begin
            mag_reg <= mag_next;
            err_reg <= err_next;
            dir_reg <= dir_next;
        end
    end

endmodule : mabsg_lane

`default_nettype wire

// ===== hdl/mabsg_merge.sv =====
// Merge stage: combines the lane findings into the major count and one result.
// Pure logic between the lanes and the output buffer.
// Depends on mabsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mabsg_merge
    import mabsg_pkg::*;
(
    input  wire logic [MAX_AXES-1:0][MAG_W-1:0] lane_mag,
    input  wire logic [MAX_AXES-1:0]            lane_pulse,
    input  wire logic [MAX_AXES-1:0]            lane_dir,
    input  wire logic                           busy,
    input  wire logic                           step,
    output logic      [MAG_W-1:0]               major_max,
    output result_t                             result
);

    // Largest magnitude over the lanes
    always_comb
    begin
        major_max = '0;
        for (int i = 0; i < MAX_AXES; i++)
        begin
            if (lane_mag[i] > major_max)
                major_max = lane_mag[i];
        end
    end

    // Result assembly; pulses only count on an executed step period
    always_comb
    begin
        result             = '0;
        result.load_status = busy ? STATUS_BUSY : STATUS_OK;
        result.running     = step;
        result.step_pulses = AXIS_W'(step ? lane_pulse : '0);
        result.dir_pins    = AXIS_W'(lane_dir);
    end

endmodule : mabsg_merge

`default_nettype wire

// ===== hdl/mabsg_outbuf.sv =====
// Output register with a skid stage, two result transactions deep.
// The input side stalls only when the skid stage is occupied.
// Depends on mabsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mabsg_outbuf
    import mabsg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg,  main_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Refill the output register from the skid stage first, then from input
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || take)
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule : mabsg_outbuf

`default_nettype wire

// ===== hdl/multi_axis_bresenham_step_generator_top.sv =====
// Results: each result is registered in the output register once its input transaction is accepted,
// or waits in the skid stage first while earlier results wait under output stall.
// Throughput: one transaction per cycle; three axis lanes step in parallel and the
// segment state updates in the accept cycle. Input stalls only while the
// output skid stage holds a result.
// Reset: async active low; segment idle, all axis state zero, axes_in_use = 3.
`timescale 1ns / 1ps
`default_nettype none

module multi_axis_bresenham_step_generator_top
    import mabsg_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic signed [STEP_BITS-1:0] steps_axis0,
    input  wire logic signed [STEP_BITS-1:0] steps_axis1,
    input  wire logic signed [STEP_BITS-1:0] steps_axis2,
    input  wire logic        [AXIS_W-1:0]    axis_enable_mask,
    // output channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             load_status,
    output logic                             running,
    output logic             [AXIS_W-1:0]    step_pulses,
    output logic             [AXIS_W-1:0]    dir_pins,
    // configuration channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic        [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] axes_reg;
    logic             active_reg, active_next;
    logic [MAG_W-1:0] major_reg,  major_next;
    logic [MAG_W-1:0] ticks_reg,  ticks_next;

    logic                           accept;
    logic                           is_load;
    logic                           load_go;
    logic                           busy;
    logic                           tick_live;
    logic                           tick_end;
    logic                           tick_step;
    logic [CFG_W-1:0]               live_n;
    logic [MAX_AXES-1:0]            lane_live;
    lane_ctrl_t [MAX_AXES-1:0]      lane_ctrl;
    logic signed [MAX_AXES-1:0][STEP_BITS-1:0] lane_steps;
    logic [MAX_AXES-1:0][MAG_W-1:0] lane_mag;
    logic [MAX_AXES-1:0]            lane_pulse;
    logic [MAX_AXES-1:0]            lane_dir;
    logic [MAG_W-1:0]               major_max;
    result_t                        result;
    result_t                        out_data;
    logic                           buf_full;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            axes_reg <= AXES_RESET;
        else if (cfg_valid && cfg_ready)
            axes_reg <= cfg_data;
    end

    // Number of live axes, clamped to one .. MAX_AXES
    always_comb
    begin
        live_n = axes_reg;
        if (live_n == '0)
            live_n = CFG_W'(1);
        else if (32'(live_n) > MAX_AXES)
            live_n = CFG_W'(MAX_AXES);
        for (int i = 0; i < MAX_AXES; i++)
            lane_live[i] = (i < 32'(live_n));
    end

    // Transaction decode
    assign in_stall  = buf_full;
    assign accept    = in_valid && !in_stall;
    assign is_load   = (func == FUNC_LOAD);
    assign load_go   = accept && is_load && !active_reg;
    assign busy      = accept && is_load && active_reg;
    assign tick_live = accept && (func == FUNC_TICK) && active_reg;
    assign tick_end  = tick_live && (ticks_reg >= major_reg);
    assign tick_step = tick_live && !(ticks_reg >= major_reg);

    assign lane_steps[0] = steps_axis0;
    assign lane_steps[1] = steps_axis1;
    assign lane_steps[2] = steps_axis2;

    // Axis lanes
    for (genvar g = 0; g < MAX_AXES; g++)
    begin : g_lane
        assign lane_ctrl[g].load = load_go;
        assign lane_ctrl[g].step = tick_step;
        assign lane_ctrl[g].live = lane_live[g];
        assign lane_ctrl[g].sel  = axis_enable_mask[g];

        mabsg_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl[g]),
            .steps       (lane_steps[g]),
            .major_count (major_reg),
            .load_mag    (lane_mag[g]),
            .pulse       (lane_pulse[g]),
            .dir_next    (lane_dir[g])
        );
    end

    mabsg_merge u_merge
    (
        .lane_mag   (lane_mag),
        .lane_pulse (lane_pulse),
        .lane_dir   (lane_dir),
        .busy       (busy),
        .step       (tick_step),
        .major_max  (major_max),
        .result     (result)
    );

    // Segment sequencing
    always_comb
    begin
        active_next = active_reg;
        major_next  = major_reg;
        ticks_next  = ticks_reg;
        if (load_go)
        begin
            active_next = 1'b1;
            major_next  = major_max;
            ticks_next  = '0;
        end
        else if (tick_end)
        begin
            active_next = 1'b0;
        end
        else if (tick_step)
        begin
            ticks_next = ticks_reg + MAG_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            major_reg  <= '0;
            ticks_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            major_reg  <= major_next;
            ticks_reg  <= ticks_next;
        end
    end

    mabsg_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign load_status = out_data.load_status;
    assign running     = out_data.running;
    assign step_pulses = out_data.step_pulses;
    assign dir_pins    = out_data.dir_pins;

endmodule : multi_axis_bresenham_step_generator_top

`default_nettype wire

// ===== hdl/mabsg_checker.sv =====
// Port-level checker for the step generator, bound to the top level.
// Depends on mabsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mabsg_checker
    import mabsg_pkg::*;
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        func,
    input wire logic signed [STEP_BITS-1:0] steps_axis0,
    input wire logic signed [STEP_BITS-1:0] steps_axis1,
    input wire logic signed [STEP_BITS-1:0] steps_axis2,
    input wire logic        [AXIS_W-1:0]    axis_enable_mask,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic                        load_status,
    input wire logic                        running,
    input wire logic        [AXIS_W-1:0]    step_pulses,
    input wire logic        [AXIS_W-1:0]    dir_pins,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic        [CFG_W-1:0]     cfg_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({load_status, running,
                                                         step_pulses, dir_pins}))
        else $error("stalled result changed");

    // Output is valid on the next cycle after every accepted transaction
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("result missing one cycle after accept");

    // A result is either a busy refusal or a step period, never both
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(load_status && running))
        else $error("busy and running both set");

    // Pulses only appear on an executed step period
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running |-> step_pulses == '0)
        else $error("step pulses without a step period");

endmodule : mabsg_checker

bind multi_axis_bresenham_step_generator_top mabsg_checker u_mabsg_checker (.*);

`default_nettype wire
